/* hdl/wspq_pkg.sv */
`default_nettype none
package wspq_pkg;

  typedef struct packed {
    logic        action;
    logic [19:0] fee_in;
    logic [31:0] arrival_time;
    logic [7:0]  complexity_in;
    logic [3:0]  tier_in;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] fee_out;
    logic [31:0] arrival_out;
    logic [7:0]  complexity_out;
    logic [3:0]  tier_out;
    logic [31:0] processed_total;
    logic [47:0] fees_total;
    logic        queue_empty;
  } out_item_t;

  typedef struct packed {
    logic [19:0] fee;
    logic [31:0] arrival;
    logic [7:0]  complexity;
    logic [3:0]  tier;
  } slot_t;

  typedef logic [255:0][16:0] recip_tab_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_POP    = 1'b1;

  localparam logic [1:0] REG_FEE_W  = 2'd0;
  localparam logic [1:0] REG_WAIT_W = 2'd1;
  localparam logic [1:0] REG_SIMP_W = 2'd2;
  localparam logic [1:0] REG_TIER_W = 2'd3;

  localparam logic [15:0] WEIGHT_RESET = 16'd16384;
  localparam logic [47:0] FEE_SUM_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] POP_MAX      = 32'hFFFF_FFFF;

  // build floor(65536 / (c + 1)) for every c by long division
  function automatic recip_tab_t make_recip_tab();
    recip_tab_t  tab;
    logic [16:0] num;
    logic [16:0] rem;
    logic [16:0] quo;
    logic [16:0] den;
    num = 17'h10000;
    for (int i = 0; i < 256; i++) begin
      den = 17'(i) + 17'd1;
      rem = '0;
      quo = '0;
      for (int b = 16; b >= 0; b--) begin
        rem = {rem[15:0], num[b]};
        if (rem >= den) begin
          rem = rem - den;
          quo[b] = 1'b1;
        end
      end
      tab[i] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = make_recip_tab();

  // floor(65536 / (c + 1))
  function automatic logic [16:0] recip_q(input logic [7:0] c);
    return RECIP_TAB[c];
  endfunction

endpackage
`default_nettype wire

/* hdl/weighted_score_priority_queue.sv */
// Weighted-score priority queue of up to CAPACITY requests.
// Issue a command by raising start while busy is low; cmd carries the item
// (action 0 inserts, action 1 pops the highest-scoring request, ties to the
// lowest slot). The single result appears on res for one cycle with done high.
// The receiver cannot stall; results must be taken as they appear.
// Insert: the lowest free slot is found by a scan, one slot per cycle. Pop:
// every slot is read from the slot memory in turn and scored by one shared
// datapath: a three-step pipeline (time difference, then the wait term through
// a reciprocal multiply by 1/3600 and the fee, simplicity and tier weight
// products, then the wait weight product, the sum and compare). The scan over
// the slots sets the rate.
// Weights are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while idle (not enforced by the block); they take effect on the next pop.
// Reset (rst, synchronous) clears all valid bits, counters and weights to
// their reset values; the slot memory itself is not cleared.
`default_nettype none
module weighted_score_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wspq_pkg::in_item_t   cmd,
  output logic                 busy,
  output logic                 done,
  output wspq_pkg::out_item_t  res,
  input  wire                  cfg_we,
  input  wire  [1:0]           cfg_index,
  input  wire  [15:0]          cfg_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_POP  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  logic [15:0] fee_w, wait_w, simp_w, tier_w;
  logic [CAPACITY-1:0] valid;
  logic [31:0] pop_count;
  logic [47:0] fee_sum;
  wspq_pkg::in_item_t req;

  wspq_pkg::slot_t mem [CAPACITY];
  wspq_pkg::slot_t rd;

  logic [CW-1:0] idx;
  logic          mem_we;
  logic [IW-1:0] wr_addr;

  // pipeline: stage0 read issued, s1 data valid
  logic          v1, v2, v3;
  logic [IW-1:0] k1, k2, k3;
  logic          ok1, ok2, ok3;
  logic signed [32:0] diff1;
  logic [16:0]   rq2;
  logic [19:0]   f2;
  logic [3:0]    t2;
  logic signed [69:0] d_mul;
  logic signed [48:0] wq;
  logic signed [66:0] p_fee, p_wait, p_simp, p_tier;
  logic signed [66:0] sc;
  logic          have_best;
  logic signed [66:0] best_score;
  logic [IW-1:0] best_k;
  logic [1:0]    out_status;
  logic          pop_ok;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {req.fee_in, req.arrival_time,
                                 req.complexity_in, req.tier_in};
    rd <= mem[idx[IW-1:0]];
  end

  // floor(diff * 2^16 / 3600): reciprocal multiply by 2^47 / 3600, then fix by one
  localparam logic [35:0] RECIP = 36'd39093746765;
  logic signed [48:0] x1;
  logic signed [48:0] q_est, r_est;
  assign x1 = 49'(diff1) <<< 16;

  always_comb begin
    d_mul = 70'(diff1) * 70'(signed'({1'b0, RECIP}));
    q_est = 49'(d_mul >>> 31);
    r_est = x1 - q_est * 49'sd3600;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      valid <= '0;
      pop_count <= '0;
      fee_sum <= '0;
      fee_w <= wspq_pkg::WEIGHT_RESET;
      wait_w <= wspq_pkg::WEIGHT_RESET;
      simp_w <= wspq_pkg::WEIGHT_RESET;
      tier_w <= wspq_pkg::WEIGHT_RESET;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      have_best <= 1'b0;
      mem_we <= 1'b0;
      idx <= '0;
    end else begin
      done <= 1'b0;
      mem_we <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          wspq_pkg::REG_FEE_W:  fee_w  <= cfg_data;
          wspq_pkg::REG_WAIT_W: wait_w <= cfg_data;
          wspq_pkg::REG_SIMP_W: simp_w <= cfg_data;
          wspq_pkg::REG_TIER_W: tier_w <= cfg_data;
          default: ;
        endcase
      end
      if (done && pop_ok) fee_sum <= res.fees_total;
      // scoring pipeline
      v1 <= (state == S_POP) && (idx < CAP_C);
      k1 <= idx[IW-1:0];
      ok1 <= (idx < CAP_C) && valid[idx[IW-1:0]];
      v2 <= v1; k2 <= k1; ok2 <= ok1;
      diff1 <= 33'(signed'({1'b0, req.current_time})) - 33'(signed'({1'b0, rd.arrival}));
      rq2 <= wspq_pkg::recip_q(rd.complexity);
      f2 <= rd.fee; t2 <= rd.tier;
      v3 <= v2; k3 <= k2; ok3 <= ok2;
      if (r_est < 0) wq <= q_est - 49'sd1;
      else if (r_est >= 49'sd3600) wq <= q_est + 49'sd1;
      else wq <= q_est;
      p_fee  <= 67'(signed'({1'b0, fee_w})) * 67'(signed'({1'b0, f2})) <<< 16;
      p_simp <= 67'(signed'({1'b0, simp_w})) * 67'(signed'({1'b0, rq2}));
      p_tier <= 67'(signed'({1'b0, tier_w})) * 67'(signed'({1'b0, t2})) <<< 16;
      if (v3 && ok3 && (!have_best || sc > best_score)) begin
        have_best <= 1'b1;
        best_score <= sc;
        best_k <= k3;
      end
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          have_best <= 1'b0;
          if (start) begin
            req <= cmd;
            state <= (cmd.action == wspq_pkg::ACTION_POP) ? S_POP : S_INS;
          end
        end
        S_INS: begin
          if (idx == CAP_C) begin
            out_status <= wspq_pkg::STATUS_FULL;
            state <= S_OUT;
          end else if (!valid[idx[IW-1:0]]) begin
            mem_we <= 1'b1;
            wr_addr <= idx[IW-1:0];
            valid[idx[IW-1:0]] <= 1'b1;
            out_status <= wspq_pkg::STATUS_OK;
            state <= S_OUT;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_POP: begin
          if (idx != CAP_C) idx <= idx + CW'(1);
          else if (!v1 && !v2 && !v3) state <= S_FIN;
        end
        S_FIN: begin
          idx <= CW'(best_k);
          state <= S_OUT;
          if (have_best) begin
            out_status <= wspq_pkg::STATUS_OK;
            valid[best_k] <= 1'b0;
            if (pop_count != wspq_pkg::POP_MAX) pop_count <= pop_count + 32'd1;
          end else begin
            out_status <= wspq_pkg::STATUS_EMPTY;
          end
        end
        S_OUT: begin
          if (!mem_we) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign p_wait = 67'(signed'({1'b0, wait_w})) * 67'(wq);
  assign sc = p_fee + p_wait + p_simp + p_tier;

  assign pop_ok = (req.action == wspq_pkg::ACTION_POP) && (out_status == wspq_pkg::STATUS_OK);

  always_comb begin
    res.status = out_status;
    res.fee_out = pop_ok ? rd.fee : '0;
    res.arrival_out = pop_ok ? rd.arrival : '0;
    res.complexity_out = pop_ok ? rd.complexity : '0;
    res.tier_out = pop_ok ? rd.tier : '0;
    res.processed_total = pop_count;
    res.fees_total = (pop_ok && !(wspq_pkg::FEE_SUM_MAX - fee_sum < 48'(rd.fee)))
                     ? fee_sum + 48'(rd.fee)
                     : (pop_ok ? wspq_pkg::FEE_SUM_MAX : fee_sum);
    res.queue_empty = ~|valid;
  end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
module tb;
  import wspq_pkg::*;

  localparam int CAPACITY = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t cmd = '0;
  logic busy, done;
  out_item_t res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_FEE_W;
  logic [15:0] cfg_data = '0;

  weighted_score_priority_queue #(.CAPACITY(CAPACITY)) u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  logic [15:0] w_fee, w_wait, w_simp, w_tier;
  slot_t       q_slot[CAPACITY];
  bit          q_valid[CAPACITY];
  logic [31:0] q_pops;
  logic [47:0] q_fees;
  out_item_t   expected_results[$];
  int          errors = 0;
  bit          calm = 1'b0;

  function automatic longint slot_score(slot_t s, logic [31:0] now);
    longint diff, num, wq, sc;
    diff = longint'({32'd0, now}) - longint'({32'd0, s.arrival});
    num = diff * 65536;
    if (num >= 0) wq = num / 3600;
    else wq = -((-num + 3599) / 3600);
    sc = longint'(w_fee) * longint'(s.fee) * 65536;
    sc += longint'(w_wait) * wq;
    sc += longint'(w_simp) * longint'(65536 / (int'(s.complexity) + 1));
    sc += longint'(w_tier) * longint'(s.tier) * 65536;
    return sc;
  endfunction

  function automatic out_item_t queue_step(in_item_t it);
    out_item_t r;
    int best;
    longint bs, sc;
    bit any;
    r = '0;
    best = -1;
    bs = 0;
    if (it.action == ACTION_INSERT) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (!q_valid[k] && best < 0) best = k;
      end
      if (best < 0) begin
        r.status = STATUS_FULL;
      end else begin
        q_slot[best] = '{it.fee_in, it.arrival_time, it.complexity_in, it.tier_in};
        q_valid[best] = 1'b1;
      end
    end else begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (q_valid[k]) begin
          sc = slot_score(q_slot[k], it.current_time);
          if (best < 0 || sc > bs) begin
            best = k;
            bs = sc;
          end
        end
      end
      if (best < 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.fee_out = q_slot[best].fee;
        r.arrival_out = q_slot[best].arrival;
        r.complexity_out = q_slot[best].complexity;
        r.tier_out = q_slot[best].tier;
        q_valid[best] = 1'b0;
        if (q_pops != POP_MAX) q_pops++;
        if (FEE_SUM_MAX - q_fees < 48'(q_slot[best].fee)) q_fees = FEE_SUM_MAX;
        else q_fees += 48'(q_slot[best].fee);
      end
    end
    any = 1'b0;
    for (int k = 0; k < CAPACITY; k++) any |= q_valid[k];
    r.processed_total = q_pops;
    r.fees_total = q_fees;
    r.queue_empty = !any;
    return r;
  endfunction

  task automatic send_item(in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 20) @(negedge clk);
    end
    while (busy) @(negedge clk);
    start <= 1'b1;
    cmd <= it;
    expected_results.insert(expected_results.size(), queue_step(it));
    @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (CAPACITY + 10) @(negedge clk);
  endtask

  task automatic write_weight(logic [1:0] idx, logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FEE_W:  w_fee = v;
      REG_WAIT_W: w_wait = v;
      REG_SIMP_W: w_simp = v;
      default:    w_tier = v;
    endcase
  endtask

  function automatic in_item_t ins(logic [19:0] f, logic [31:0] a, logic [7:0] c,
                                   logic [3:0] t);
    in_item_t it;
    it = '0;
    it.action = ACTION_INSERT;
    it.fee_in = f;
    it.arrival_time = a;
    it.complexity_in = c;
    it.tier_in = t;
    it.current_time = $urandom;
    return it;
  endfunction

  function automatic in_item_t pop(logic [31:0] now);
    in_item_t it;
    it = '0;
    it.action = ACTION_POP;
    it.fee_in = 20'($urandom);
    it.arrival_time = $urandom;
    it.complexity_in = 8'($urandom);
    it.tier_in = 4'($urandom);
    it.current_time = now;
    return it;
  endfunction

  function automatic in_item_t rand_insert();
    return ins($urandom_range(3) == 0 ? 20'hFFFFF : 20'($urandom_range(2000)),
               $urandom, 8'($urandom), 4'($urandom));
  endfunction

  task automatic test_edges();
    send_item(pop(32'd0));
    send_item(ins(20'hFFFFF, 32'hFFFFFFFF, 8'hFF, 4'hF));
    send_item(ins(20'd0, 32'd0, 8'd0, 4'd0));
    send_item(ins(20'd5, 32'd1000, 8'd3, 4'd2));
    send_item(ins(20'd5, 32'd1000, 8'd3, 4'd2));
    send_item(pop(32'd0));
    send_item(pop(32'hFFFFFFFF));
    send_item(pop(32'd500));
    send_item(pop(32'd500));
    send_item(pop(32'd0));
  endtask

  task automatic test_full();
    for (int k = 0; k < CAPACITY + 3; k++) send_item(rand_insert());
    for (int k = 0; k < CAPACITY + 2; k++) send_item(pop($urandom));
  endtask

  task automatic test_weights();
    logic [15:0] v;
    for (int p = 0; p < 6; p++) begin
      for (int r = 0; r < 4; r++) begin
        case ($urandom_range(2))
          0: v = 16'd0;
          1: v = 16'hFFFF;
          default: v = 16'($urandom);
        endcase
        write_weight(2'(r), v);
      end
      repeat (40) begin
        if ($urandom_range(99) < 55) send_item(rand_insert());
        else send_item(pop($urandom));
      end
    end
  endtask

  task automatic test_random();
    for (int k = 0; k < 200; k++) begin
      calm = (k >= 60 && k < 120);
      if (k == 150) drain();
      if ($urandom_range(99) < 50) send_item(rand_insert());
      else send_item(pop($urandom));
    end
    calm = 1'b0;
  endtask

  task automatic test_fee_saturation();
    write_weight(REG_FEE_W, 16'hFFFF);
    for (int k = 0; k < 60; k++) begin
      send_item(ins(20'hFFFFF, $urandom, 8'($urandom), 4'($urandom)));
      send_item(pop($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, res);
        errors++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (res !== e) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, e, res);
          errors++;
        end
      end
    end
  end

  initial begin
    w_fee = WEIGHT_RESET;
    w_wait = WEIGHT_RESET;
    w_simp = WEIGHT_RESET;
    w_tier = WEIGHT_RESET;
    q_pops = '0;
    q_fees = '0;
    for (int k = 0; k < CAPACITY; k++) q_valid[k] = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_edges();
    test_full();
    test_weights();
    test_random();
    test_fee_saturation();
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* sim.f */
hdl/wspq_pkg.sv
hdl/weighted_score_priority_queue.sv
tb/sv/tb.sv
